### rtl/tlcb_pkg.sv
// Shared constants, widths and result type for the terminal line cursor buffer.
// Depends on nothing; imported by the channel interfaces and the top level.
package tlcb_pkg;

    // Line geometry
    localparam int MAX_COLUMNS = 32;
    localparam int CHAR_W      = 16;
    localparam int LEN_W       = $clog2(MAX_COLUMNS + 1);
    localparam int ADDR_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 16'h0008;

    // Line kinds
    localparam logic KIND_COMMIT   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    // One result transaction
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              line_kind;
        logic              line_last;
        logic              overflow;
    } t_out_item;

endpackage

### rtl/tlcb_if.sv
// Valid/ready channel interfaces for character input and line output.
// Depends on tlcb_pkg for the character width.
interface tlcb_in_if import tlcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              chunk_end;

    modport source (output valid, output char_code, output chunk_end, input ready);
    modport sink   (input valid, input char_code, input chunk_end, output ready);
endinterface

interface tlcb_out_if import tlcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              line_kind;
    logic              line_last;
    logic              overflow;

    modport source (output valid, output out_char, output char_valid, output line_kind,
                    output line_last, output overflow, input ready);
    modport sink   (input valid, input out_char, input char_valid, input line_kind,
                    input line_last, input overflow, output ready);
endinterface

### rtl/terminal_line_cursor_buffer.sv
// Terminal line buffer: an ordinary, carriage return or backspace character is taken
// while idle. A newline or chunk end reads the line out of the store RAM column by column
// (read, then load the output register), and the input is held off until the line is out;
// output stalls lengthen this. The first result passes through S_READ, S_OUT and the output
// register (S_EMPTY and the output register for an empty line).
// Reset (synchronous, active low) clears length, cursor, overflow and the controller;
// the line store is not cleared, as columns are read only after being written.
module terminal_line_cursor_buffer import tlcb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlcb_in_if.sink       i_in,
    tlcb_out_if.source    o_out
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT, S_EMPTY} t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_length, n_length;
    logic [LEN_W-1:0]  r_cursor, n_cursor;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic              r_ovf, n_ovf;
    logic              r_kind, n_kind;
    logic              r_chunk_pend, n_chunk_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic              is_nl, is_cr, is_bs;
    logic              line_done;
    logic              load_out;
    logic              ram_we, ram_re;
    logic [CHAR_W-1:0] ram_rdata;

    // Line store; writes only happen while idle and reads only while emitting,
    // so the two never touch the same entry in one cycle
    tlcb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cursor[ADDR_W-1:0]),
        .i_wdata (i_in.char_code),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign is_nl = (i_in.char_code == CH_NEWLINE);
    assign is_cr = (i_in.char_code == CH_RETURN);
    assign is_bs = (i_in.char_code == CH_BACKSPACE);

    // Edit the line, sequence the read-out and load the output register
    always_comb begin
        n_state      = r_state;
        n_length     = r_length;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_ovf        = r_ovf;
        n_kind       = r_kind;
        n_chunk_pend = r_chunk_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        line_done    = 1'b0;
        load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_nl) begin
                        n_kind       = KIND_COMMIT;
                        n_chunk_pend = i_in.chunk_end;
                        n_idx        = '0;
                        n_state      = (r_length == '0) ? S_EMPTY : S_READ;
                    end else begin
                        if (is_cr) begin
                            n_cursor = '0;
                        end else if (is_bs) begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - LEN_W'(1);
                            end
                        end else if (r_cursor < r_length) begin
                            // Overwrite at the cursor
                            ram_we   = 1'b1;
                            n_cursor = r_cursor + LEN_W'(1);
                        end else if (r_length < LEN_W'(MAX_COLUMNS)) begin
                            // Extend the line; cursor sits at its end
                            ram_we   = 1'b1;
                            n_length = r_length + LEN_W'(1);
                            n_cursor = r_length + LEN_W'(1);
                        end else begin
                            // Drop the character on a full line
                            n_ovf = 1'b1;
                        end
                        if (i_in.chunk_end) begin
                            n_kind  = KIND_SNAPSHOT;
                            n_idx   = '0;
                            n_state = (n_length == '0) ? S_EMPTY : S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    load_out         = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.out_char   = ram_rdata;
                    n_out.char_valid = 1'b1;
                    n_out.line_kind  = r_kind;
                    n_out.line_last  = ((r_idx + LEN_W'(1)) == r_length);
                    n_out.overflow   = r_ovf;
                    if ((r_idx + LEN_W'(1)) == r_length) begin
                        line_done = 1'b1;
                    end else begin
                        n_idx   = r_idx + LEN_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    load_out         = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.out_char   = '0;
                    n_out.char_valid = 1'b0;
                    n_out.line_kind  = r_kind;
                    n_out.line_last  = 1'b1;
                    n_out.overflow   = r_ovf;
                    line_done        = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Close the line: a commit clears it, then a pending chunk end snapshots it empty
        if (line_done) begin
            n_state = S_IDLE;
            if (r_kind == KIND_COMMIT) begin
                n_length = '0;
                n_cursor = '0;
                n_ovf    = 1'b0;
                if (r_chunk_pend) begin
                    n_chunk_pend = 1'b0;
                    n_kind       = KIND_SNAPSHOT;
                    n_state      = S_EMPTY;
                end
            end
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_length     <= '0;
            r_cursor     <= '0;
            r_idx        <= '0;
            r_ovf        <= 1'b0;
            r_kind       <= KIND_COMMIT;
            r_chunk_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_length     <= n_length;
            r_cursor     <= n_cursor;
            r_idx        <= n_idx;
            r_ovf        <= n_ovf;
            r_kind       <= n_kind;
            r_chunk_pend <= n_chunk_pend;
            r_out_valid  <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_out.out_char;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.line_kind  = r_out.line_kind;
    assign o_out.line_last  = r_out.line_last;
    assign o_out.overflow   = r_out.overflow;

    // Cursor never passes the end of the line
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_length)
        else $error("cursor beyond line length");

    // Line length stays within the store
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length <= LEN_W'(MAX_COLUMNS))
        else $error("line length beyond store depth");

    // An empty-line result is only produced for a line of zero length
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && !n_out.char_valid |-> r_length == '0)
        else $error("empty result for a non-empty line");

    // A pending snapshot only rides along with a commit in progress
    a_chunk_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_pend |-> (r_kind == KIND_COMMIT) && (r_state != S_IDLE))
        else $error("snapshot pending outside a commit");

    // A committed line leaves the buffer empty afterwards
    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_done && (r_kind == KIND_COMMIT) |=> (r_length == '0) && !r_ovf)
        else $error("line not cleared after commit");

endmodule

### rtl/tlcb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tlcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
